FILE: rtl/sds_pkg.sv
// shared types and constants of the scan disk scheduler
`timescale 1ns / 1ps
`default_nettype none
package sds_pkg;

   // field widths
   localparam int CYL_W       = 16;
   localparam int MOVE_W      = 17;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 40;

   // saturation bound of the travel sum
   localparam logic [MOVE_W-1:0] MOVE_MAX = 17'h1FFFF;

   // reset value of the last cylinder register
   localparam logic [CYL_W-1:0] LAST_CYL_RESET = 16'd199;

   // operation codes carried in req_tuser
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   // one result handed from the sequencer to the output stage
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             turn;
      logic             last;
      logic [CYL_W-1:0] cyl;
   } emit_type;

endpackage
`default_nettype wire

FILE: rtl/sds_store_ram.sv
// request store: one write port, one read port with registered data
`timescale 1ns / 1ps
`default_nettype none
module sds_store_ram #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire logic [sds_pkg::CYL_W-1:0] wr_data,
   input  wire logic                   rd_en,
   input  wire logic [AW-1:0]          rd_addr,
   output logic      [sds_pkg::CYL_W-1:0] rd_data
);
   import sds_pkg::*;

   logic [CYL_W-1:0] store_ff [DEPTH];
   logic [CYL_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/sds_out.sv
// output register and head travel accumulator
`timescale 1ns / 1ps
`default_nettype none
module sds_out (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire sds_pkg::emit_type             emit,
   output logic                               out_free,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [15:0] cylinder, [32:16] total_movement, [39:33] zero
   output logic [sds_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] is_turn_point
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);
   import sds_pkg::*;

   localparam int PAD_W = RSP_DATA_W - MOVE_W - CYL_W;

   logic              valid_ff, valid_in;
   logic [CYL_W-1:0]  cyl_ff;
   logic              turn_ff;
   logic              last_ff;
   logic [MOVE_W-1:0] total_ff, total_in;
   logic [MOVE_W-1:0] travel_ff, travel_in;
   logic [CYL_W-1:0]  prev_ff;
   logic [CYL_W-1:0]  step;
   logic [MOVE_W:0]   sum;
   logic [MOVE_W-1:0] sat;

   assign out_free = !valid_ff || rsp_tready;

   // distance from the previous result, saturating sum
   always_comb begin
      step = (emit.cyl >= prev_ff) ? (emit.cyl - prev_ff) : (prev_ff - emit.cyl);
      sum  = {1'b0, travel_ff} + (MOVE_W + 1)'(step);
      sat  = sum[MOVE_W] ? MOVE_MAX : sum[MOVE_W-1:0];
   end

   always_comb begin
      valid_in  = valid_ff;
      travel_in = travel_ff;
      total_in  = total_ff;
      if (emit.valid) begin
         valid_in  = 1'b1;
         travel_in = emit.first ? '0 : sat;
         total_in  = (emit.last && !emit.first) ? sat : '0;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (emit.valid) begin
         cyl_ff    <= emit.cyl;
         turn_ff   <= emit.turn;
         last_ff   <= emit.last;
         total_ff  <= total_in;
         travel_ff <= travel_in;
         prev_ff   <= emit.cyl;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, total_ff, cyl_ff};
   assign rsp_tuser  = turn_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

FILE: rtl/sds_ctrl.sv
// sequencer: sorted insertion into the store, head placement and sweep walk
`timescale 1ns / 1ps
`default_nettype none
module sds_ctrl #(
   parameter int MAX_REQUESTS = 32,
   parameter int AW           = 5,
   parameter int CW           = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic                       in_op,
   input  wire logic [sds_pkg::CYL_W-1:0]  in_req_cyl,
   input  wire logic [sds_pkg::CYL_W-1:0]  in_head,
   input  wire logic [sds_pkg::CYL_W-1:0]  last_cyl,
   input  wire logic                       out_free,
   output sds_pkg::emit_type               emit,
   output logic                            ram_we,
   output logic [AW-1:0]                   ram_waddr,
   output logic [sds_pkg::CYL_W-1:0]       ram_wdata,
   output logic                            ram_re,
   output logic [AW-1:0]                   ram_raddr,
   input  wire logic [sds_pkg::CYL_W-1:0]  ram_rdata
);
   import sds_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_INS      = 8'b0000_0010,
      ST_INS_LAST = 8'b0000_0100,
      ST_SCAN     = 8'b0000_1000,
      ST_HEAD     = 8'b0001_0000,
      ST_FETCH    = 8'b0010_0000,
      ST_EMIT     = 8'b0100_0000,
      ST_TURN     = 8'b1000_0000
   } state_type;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REQUESTS);

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CYL_W-1:0] val_ff, val_in;
   logic             up_ff, up_in;
   logic             second_ff, second_in;
   logic [CW-1:0]    p_ff, p_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    rem_ff, rem_in;

   logic [CW-1:0]    p_m1;
   logic [CW-1:0]    cnt_m1;
   logic [CW-1:0]    ptr_p1;
   logic [CW-1:0]    hi_cnt;
   logic [CW-1:0]    sec_cnt;
   logic [AW-1:0]    asc_ptr;
   logic [AW-1:0]    desc_ptr;
   logic             asc;
   logic             hit;

   assign in_ready = (state_ff == ST_IDLE);

   // sweep bounds derived from the split point
   always_comb begin
      p_m1     = p_ff - CW'(1);
      cnt_m1   = count_ff - CW'(1);
      ptr_p1   = CW'(ptr_ff) + CW'(1);
      hi_cnt   = count_ff - p_ff;
      sec_cnt  = up_ff ? p_ff : hi_cnt;
      asc_ptr  = p_ff[AW-1:0];
      desc_ptr = p_m1[AW-1:0];
      asc      = up_ff ^ second_ff;
      hit      = up_ff ? (ram_rdata < val_ff) : (ram_rdata <= val_ff);
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      val_in    = val_ff;
      up_in     = up_ff;
      second_in = second_ff;
      p_in      = p_ff;
      ptr_in    = ptr_ff;
      rem_in    = rem_ff;
      ram_we    = 1'b0;
      ram_waddr = ptr_p1[AW-1:0];
      ram_wdata = val_ff;
      ram_re    = 1'b0;
      ram_raddr = ptr_ff;
      emit      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (in_op == OP_ADD) begin
                  if (count_ff < MAX_CNT) begin
                     val_in = in_req_cyl;
                     if (count_ff == '0) begin
                        state_in = ST_INS_LAST;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = cnt_m1[AW-1:0];
                        ptr_in    = cnt_m1[AW-1:0];
                        state_in  = ST_INS;
                     end
                  end
               end else begin
                  val_in    = in_head;
                  up_in     = in_head > (last_cyl >> 1);
                  second_in = 1'b0;
                  p_in      = '0;
                  if (count_ff == '0) begin
                     state_in = ST_HEAD;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     ptr_in    = '0;
                     state_in  = ST_SCAN;
                  end
               end
            end
         end

         // shift larger entries up by one until the slot is found
         ST_INS: begin
            ram_we = 1'b1;
            if (ram_rdata > val_ff) begin
               ram_wdata = ram_rdata;
               if (ptr_ff == '0) begin
                  state_in = ST_INS_LAST;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ptr_ff - AW'(1);
                  ptr_in    = ptr_ff - AW'(1);
               end
            end else begin
               count_in = count_ff + CW'(1);
               state_in = ST_IDLE;
            end
         end

         ST_INS_LAST: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            count_in  = count_ff + CW'(1);
            state_in  = ST_IDLE;
         end

         // count entries below the head (at or below it on a downward run): the split point
         ST_SCAN: begin
            if (hit) begin
               if (ptr_p1 == count_ff) begin
                  p_in     = count_ff;
                  state_in = ST_HEAD;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ptr_p1[AW-1:0];
                  ptr_in    = ptr_p1[AW-1:0];
               end
            end else begin
               p_in     = CW'(ptr_ff);
               state_in = ST_HEAD;
            end
         end

         ST_HEAD: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.first = 1'b1;
               emit.cyl   = val_ff;
               ptr_in     = up_ff ? asc_ptr : desc_ptr;
               rem_in     = up_ff ? hi_cnt : p_ff;
               state_in   = ST_FETCH;
            end
         end

         ST_FETCH: begin
            if (rem_ff == '0) begin
               if (!second_ff) begin
                  state_in = ST_TURN;
               end else begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end
            end else begin
               ram_re   = 1'b1;
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.cyl   = ram_rdata;
               emit.last  = second_ff && (rem_ff == CW'(1));
               rem_in     = rem_ff - CW'(1);
               ptr_in     = asc ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));
               if (emit.last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end

         ST_TURN: begin
            if (out_free) begin
               emit.valid = 1'b1;
               emit.turn  = 1'b1;
               emit.cyl   = up_ff ? last_cyl : '0;
               emit.last  = (sec_cnt == '0);
               if (emit.last) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  second_in = 1'b1;
                  ptr_in    = up_ff ? desc_ptr : asc_ptr;
                  rem_in    = sec_cnt;
                  state_in  = ST_FETCH;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      up_ff     <= up_in;
      second_ff <= second_in;
      p_ff      <= p_in;
      ptr_ff    <= ptr_in;
      rem_ff    <= rem_in;
   end

`ifndef SYNTH
   // fill count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("request count beyond store depth");

   // a result is only handed over when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("result emitted into a busy output register");

   // the store is empty after the final result of a run
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.last) |=> (count_ff == '0) && (state_ff == ST_IDLE))
      else $error("store not emptied after final result");

   // writes land inside the store
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (CW'(ram_waddr) < MAX_CNT))
      else $error("store write beyond depth");
`endif

endmodule
`default_nettype wire

FILE: rtl/scan_disk_scheduler_top.sv
// Top level of the SCAN (elevator) disk scheduler.
// req channel: each transfer is one item. req_tuser selects the operation
// (0 adds a pending cylinder request, 1 runs the schedule). An add is
// inserted into the sorted store by shifting each stored entry above the
// new value up by one and writing the new value into the gap. An add to a
// full store is dropped.
// A run places the head among the sorted requests (one store read per
// request on the low side of the head, plus one for the first request
// past it), then returns the results on the rsp channel:
// the head, the requests of the first sweep, the turnaround cylinder and
// the requests of the return sweep. Each stored request passes through a
// store read, then an output load; the head needs only the output load and
// the turnaround an empty fetch step, then the output load.
// rsp_tlast marks the final result, which carries the total travel.
// The store has one read port. A new item is accepted once the previous
// one has been fully handed to the output register; the final result may
// still wait there. When the receiver stalls, the result is held in the
// output register and the walk pauses. Reset empties the store and sets
// last_cylinder to 199. csr_wr_en writes last_cylinder and must be used
// only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module scan_disk_scheduler_top #(
   parameter int MAX_REQUESTS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [15:0] request_cylinder, [31:16] head_position
   input  wire logic [sds_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  wire logic                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [15:0] cylinder, [32:16] total_movement, [39:33] zero
   output logic [sds_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] is_turn_point
   output logic                               rsp_tuser,
   output logic                               rsp_tlast,
   input  wire logic                          csr_wr_en,
   input  wire logic [sds_pkg::CYL_W-1:0]     csr_wr_data
);
   import sds_pkg::*;

   localparam int AW = $clog2(MAX_REQUESTS);
   localparam int CW = $clog2(MAX_REQUESTS + 1);

   logic [CYL_W-1:0] last_cyl_ff, last_cyl_in;
   emit_type         emit;
   logic             out_free;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr;
   logic [CYL_W-1:0] ram_wdata;
   logic             ram_re;
   logic [AW-1:0]    ram_raddr;
   logic [CYL_W-1:0] ram_rdata;

   // last cylinder register
   assign last_cyl_in = csr_wr_en ? csr_wr_data : last_cyl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_cyl_ff <= LAST_CYL_RESET;
      end else begin
         last_cyl_ff <= last_cyl_in;
      end
   end

   // sequencer
   sds_ctrl #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .AW           (AW),
      .CW           (CW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_req_cyl (req_tdata[CYL_W-1:0]),
      .in_head    (req_tdata[2*CYL_W-1:CYL_W]),
      .last_cyl   (last_cyl_ff),
      .out_free   (out_free),
      .emit       (emit),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   // request store
   sds_store_ram #(
      .DEPTH (MAX_REQUESTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // output register and travel sum
   sds_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

FILE: tb/tb.sv
// testbench of the scan disk scheduler: request streams checked against a scan-order predictor
`timescale 1ns / 1ps
module tb;
   import sds_pkg::*;

   localparam int MAX_REQUESTS = 32;
   // cycles an add may still be busy inserting after the last result
   localparam int ADD_SETTLE   = 80;

   // one predicted visit of the head
   typedef struct {
      logic [CYL_W-1:0]  cyl;
      logic              turn;
      logic              last;
      logic [MOVE_W-1:0] move;
   } sweep_visit_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = OP_ADD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [CYL_W-1:0]      csr_wr_data = '0;

   // predictor state
   logic [CYL_W-1:0] pending_reqs[$];
   logic [CYL_W-1:0] last_cyl_model = LAST_CYL_RESET;
   sweep_visit_type  expected_visits[$];
   int unsigned      sweep_travel;
   logic [CYL_W-1:0] sweep_pos;
   int               sweep_left;

   int mismatch_count = 0;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_left = 0;

   scan_disk_scheduler_top #(.MAX_REQUESTS(MAX_REQUESTS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #3_000_000;
      $display("scan_disk_scheduler_top test failed");
      $finish;
   end

   // queue one visit, the final one carries the saturated travel
   task automatic emit_visit(input logic [CYL_W-1:0] cyl, input logic turn);
      sweep_visit_type vis;
      int unsigned     step;
      step = (cyl >= sweep_pos) ? cyl - sweep_pos : sweep_pos - cyl;
      sweep_travel += step;
      sweep_pos = cyl;
      sweep_left--;
      vis.cyl  = cyl;
      vis.turn = turn;
      vis.last = (sweep_left == 0);
      if (vis.last)
         vis.move = (sweep_travel > MOVE_MAX) ? MOVE_MAX : sweep_travel[MOVE_W-1:0];
      else
         vis.move = '0;
      expected_visits.push_back(vis);
   endtask

   // scan order of the pending requests for one head position
   task automatic predict_schedule(input logic [CYL_W-1:0] head);
      logic [CYL_W-1:0] srt[MAX_REQUESTS];
      logic [CYL_W-1:0] v;
      int               n, i, j, p;
      n = pending_reqs.size();
      for (i = 0; i < n; i++) begin
         v = pending_reqs[i];
         j = i;
         while (j > 0 && srt[j-1] > v) begin
            srt[j] = srt[j-1];
            j--;
         end
         srt[j] = v;
      end
      sweep_travel = 0;
      sweep_pos = head;
      sweep_left = n + 2;
      emit_visit(head, 1'b0);
      p = 0;
      if (head > (last_cyl_model >> 1)) begin
         // upward sweep first, requests equal to the head go with it
         while (p < n && srt[p] < head) p++;
         for (i = p; i < n; i++) emit_visit(srt[i], 1'b0);
         emit_visit(last_cyl_model, 1'b1);
         for (i = p - 1; i >= 0; i--) emit_visit(srt[i], 1'b0);
      end else begin
         // downward sweep first
         while (p < n && srt[p] <= head) p++;
         for (i = p - 1; i >= 0; i--) emit_visit(srt[i], 1'b0);
         emit_visit('0, 1'b1);
         for (i = p; i < n; i++) emit_visit(srt[i], 1'b0);
      end
      pending_reqs.delete();
   endtask

   // offer one item with random idle gaps, predict on transfer
   task automatic send_item(input logic op, input logic [CYL_W-1:0] req_cyl,
                            input logic [CYL_W-1:0] head);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {head, req_cyl};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_ADD) begin
         if (pending_reqs.size() < MAX_REQUESTS) pending_reqs.push_back(req_cyl);
      end else begin
         predict_schedule(head);
      end
   endtask

   task automatic add_request(input logic [CYL_W-1:0] cyl);
      send_item(OP_ADD, cyl, CYL_W'($urandom));
   endtask

   task automatic run_schedule(input logic [CYL_W-1:0] head);
      send_item(OP_RUN, CYL_W'($urandom), head);
   endtask

   // stop offering and wait until every result has come back
   task automatic drain;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_visits.size() != 0) @(posedge clock);
   endtask

   // write last_cylinder while the block is idle
   task automatic write_last_cyl(input logic [CYL_W-1:0] value);
      drain();
      repeat (ADD_SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= CYL_W'($urandom);
      last_cyl_model = value;
   endtask

   // cylinder values biased to the edges and the configured range
   function automatic logic [CYL_W-1:0] pick_cyl();
      case ($urandom_range(6))
         0: return '0;
         1: return '1;
         2: return last_cyl_model;
         3, 4: return CYL_W'($urandom_range(0, last_cyl_model));
         default: return CYL_W'($urandom);
      endcase
   endfunction

   // receiver: long hold when asked, otherwise random stalls
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // compare each result transfer with the oldest expected visit
   always @(posedge clock) begin
      sweep_visit_type vis;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_visits.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: cyl %0d turn %0b last %0b move %0d",
                        rsp_tdata[15:0], rsp_tuser, rsp_tlast, rsp_tdata[32:16]);
         end else begin
            vis = expected_visits.pop_front();
            if (rsp_tdata[15:0] !== vis.cyl || rsp_tuser !== vis.turn ||
                rsp_tlast !== vis.last || rsp_tdata[32:16] !== vis.move ||
                rsp_tdata[39:33] !== '0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: exp cyl %0d turn %0b last %0b move %0d pad 0",
                           vis.cyl, vis.turn, vis.last, vis.move);
                  $display("          act cyl %0d turn %0b last %0b move %0d pad %0h",
                           rsp_tdata[15:0], rsp_tuser, rsp_tlast, rsp_tdata[32:16],
                           rsp_tdata[39:33]);
               end
            end
         end
      end
   end

   // edge heads, duplicates, requests at the head and past the last cylinder
   task automatic test_directed;
      run_schedule(16'd0);
      run_schedule(16'hFFFF);
      add_request(16'd0);
      add_request(16'hFFFF);
      add_request(16'd100);
      add_request(16'd99);
      add_request(16'd50);
      add_request(16'd50);
      run_schedule(16'd50);
      add_request(16'd150);
      add_request(16'd199);
      add_request(16'd200);
      run_schedule(16'd150);
      // one-sided stores
      add_request(16'd10);
      add_request(16'd20);
      run_schedule(16'd199);
      add_request(16'd180);
      run_schedule(16'd0);
      // direction boundary at half the last cylinder
      add_request(16'd99);
      run_schedule(16'd99);
      add_request(16'd99);
      run_schedule(16'd100);
      drain();
   endtask

   // smallest and largest last cylinder
   task automatic test_config_extremes;
      write_last_cyl(16'd1);
      add_request(16'd0);
      add_request(16'd1);
      add_request(16'd5);
      run_schedule(16'd1);
      run_schedule(16'd0);
      write_last_cyl(16'hFFFF);
      add_request(16'hFFFF);
      add_request(16'd0);
      run_schedule(16'd32768);
      run_schedule(16'd32767);
      drain();
   endtask

   // adds past a full store are dropped
   task automatic test_store_full;
      write_last_cyl(LAST_CYL_RESET);
      for (int i = 0; i < MAX_REQUESTS + 2; i++) add_request(pick_cyl());
      run_schedule(pick_cyl());
      drain();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure;
      @(posedge clock);
      hold_left = 400;
      for (int i = 0; i < 8; i++) add_request(pick_cyl());
      run_schedule(pick_cyl());
      for (int i = 0; i < 5; i++) add_request(pick_cyl());
      run_schedule(pick_cyl());
      drain();
   endtask

   // batches of adds closed by a run, with occasional register changes
   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input int item_goal);
      int sent;
      int k;
      sent = 0;
      write_last_cyl(CYL_W'($urandom_range(1, 16'hFFFF)));
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      while (sent < item_goal) begin
         if ($urandom_range(7) == 0) k = $urandom_range(20, MAX_REQUESTS + 2);
         else k = $urandom_range(0, 8);
         for (int i = 0; i < k; i++) add_request(pick_cyl());
         run_schedule(pick_cyl());
         sent += k + 1;
         if ($urandom_range(4) == 0) begin
            case ($urandom_range(3))
               0: write_last_cyl(16'd1);
               1: write_last_cyl(16'hFFFF);
               2: write_last_cyl(LAST_CYL_RESET);
               default: write_last_cyl(CYL_W'($urandom_range(1, 16'hFFFF)));
            endcase
         end
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      req_idle_pct = 20;
      rsp_idle_pct = 81;
      test_directed();
      test_config_extremes();
      test_store_full();
      test_backpressure();
      test_random_traffic(20, 81, 40);
      test_random_traffic(81, 20, 40);
      test_random_traffic(0, 0, 40);
      drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_visits.size() == 0)
         $display("scan_disk_scheduler_top test passed");
      else
         $display("scan_disk_scheduler_top test failed");
      $finish;
   end

endmodule

FILE: scan_disk_scheduler_top.f
rtl/sds_pkg.sv
rtl/sds_store_ram.sv
rtl/sds_out.sv
rtl/sds_ctrl.sv
rtl/scan_disk_scheduler_top.sv
tb/tb.sv
